// ----- design/assert_macros.svh -----
// Assertion macros used by the top-level design file of the point rotation block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define PRA_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("point rotation assertion failed");
`define PRA_ASSERT_NOW(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("point rotation condition failed");
`else
`define PRA_ASSERT(label, clk, rst, prop)
`define PRA_ASSERT_NOW(label, clk, rst, cond)
`endif
`endif

// ----- design/pra_pkg.sv -----
// Types, constants and the arctangent table of the point rotation block.
package pra_pkg;

   localparam int TRIG_W    = 32;
   localparam int Z_W       = 34;
   localparam int TRIG_FRAC = 30;
   localparam int ATAN_LEN  = 32;

   localparam logic signed [TRIG_W-1:0] GAIN_Q30 = 32'sd652032874;

   localparam logic [31:0] ATAN_TURN [ATAN_LEN] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
      32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
      32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
      32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
      32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
      32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
      32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
   };

   localparam logic [1:0] PP_AC  = 2'd0;
   localparam logic [1:0] PP_BNS = 2'd1;
   localparam logic [1:0] PP_AS  = 2'd2;
   localparam logic [1:0] PP_BC  = 2'd3;

   typedef enum logic [1:0] {
      AXIS_X    = 2'd0,
      AXIS_Y    = 2'd1,
      AXIS_Z    = 2'd2,
      AXIS_NONE = 2'd3
   } axis_type;

   typedef enum logic [1:0] {
      QUAD_0 = 2'd0,
      QUAD_1 = 2'd1,
      QUAD_2 = 2'd2,
      QUAD_3 = 2'd3
   } quad_type;

   typedef struct packed {
      logic     valid;
      axis_type axis;
      quad_type quad;
   } pipe_ctl_type;

endpackage

// ----- design/pra_req_if.sv -----
// Request channel interface carrying one point and its rotation.
interface pra_req_if #(
   parameter int COORD_WIDTH = 32,
   parameter int ANGLE_WIDTH = 16
) ();
   logic                          valid;
   logic                          ready;
   logic [1:0]                    cmd;
   logic [ANGLE_WIDTH-1:0]        angle;
   logic signed [COORD_WIDTH-1:0] in_x;
   logic signed [COORD_WIDTH-1:0] in_y;
   logic signed [COORD_WIDTH-1:0] in_z;

   modport source (output valid, cmd, angle, in_x, in_y, in_z, input ready);
   modport sink (input valid, cmd, angle, in_x, in_y, in_z, output ready);
endinterface

// ----- design/pra_rsp_if.sv -----
// Response channel interface carrying one rotated point.
interface pra_rsp_if #(
   parameter int COORD_WIDTH = 32
) ();
   logic                          valid;
   logic                          ready;
   logic signed [COORD_WIDTH-1:0] out_x;
   logic signed [COORD_WIDTH-1:0] out_y;
   logic signed [COORD_WIDTH-1:0] out_z;

   modport source (output valid, out_x, out_y, out_z, input ready);
   modport sink (input valid, out_x, out_y, out_z, output ready);
endinterface

// ----- design/point_rotate_about_axis.sv -----
// Top level of the pipelined point rotation about a principal axis.
//
// channel   direction   handshake     word
// req_if    in          valid/ready   cmd, angle, in_x, in_y, in_z
// rsp_if    out         valid/ready   out_x, out_y, out_z
//
// One word enters per cycle while no stall holds the pipeline.
// Each word passes the input register, the unrolled CORDIC with one registered
// iteration per stage, and then the multiply, product and rounding registers.
// Reset clears every stage's valid bit; payload registers are not reset.
// A stage holds while the stage after it is full and blocked, so empty stages
// still take words and a stall drops or repeats nothing.
`include "assert_macros.svh"

module point_rotate_about_axis #(
   parameter int COORD_WIDTH   = 32,
   parameter int ANGLE_WIDTH   = 16,
   parameter int CORDIC_STAGES = 16
) (
   input  logic     clock,
   input  logic     reset,
   pra_req_if.sink  req_if,
   pra_rsp_if.source rsp_if
);

   localparam int NUM_STAGES = CORDIC_STAGES + 4;
   localparam int MUL_IDX    = CORDIC_STAGES + 1;
   localparam int JOIN_IDX   = CORDIC_STAGES + 2;
   localparam int OUT_IDX    = CORDIC_STAGES + 3;
   localparam int LO_W       = COORD_WIDTH / 2;
   localparam int HPP_W      = COORD_WIDTH - LO_W + pra_pkg::TRIG_W;
   localparam int LPP_W      = LO_W + 1 + pra_pkg::TRIG_W;

   wire [NUM_STAGES-1:0] vld;
   wire [NUM_STAGES:0]   stage_ready;

   pra_pkg::pipe_ctl_type             req_ctl;
   pra_pkg::pipe_ctl_type             cord_ctl   [CORDIC_STAGES+1];
   logic [3*COORD_WIDTH-1:0]          cord_point [CORDIC_STAGES+1];
   logic signed [pra_pkg::TRIG_W-1:0] cord_cx    [CORDIC_STAGES+1];
   logic signed [pra_pkg::TRIG_W-1:0] cord_cy    [CORDIC_STAGES+1];
   logic signed [pra_pkg::Z_W-1:0]    cord_cz    [CORDIC_STAGES+1];

   pra_pkg::pipe_ctl_type             mul_ctl;
   logic [3*COORD_WIDTH-1:0]          mul_point;
   logic signed [HPP_W-1:0]           mul_hi [4];
   logic signed [LPP_W-1:0]           mul_lo [4];

   logic                              join_valid;
   pra_pkg::pipe_ctl_type             out_ctl;

   assign req_ctl = '{valid: req_if.valid,
                      axis: pra_pkg::axis_type'(req_if.cmd),
                      quad: pra_pkg::QUAD_0};

   pra_angle_prep #(
      .COORD_WIDTH (COORD_WIDTH),
      .ANGLE_WIDTH (ANGLE_WIDTH)
   ) u_prep (
      .clock    (clock),
      .reset    (reset),
      .load     (stage_ready[0]),
      .up_ctl   (req_ctl),
      .up_angle (req_if.angle),
      .up_point ({req_if.in_z, req_if.in_y, req_if.in_x}),
      .dn_ctl   (cord_ctl[0]),
      .dn_point (cord_point[0]),
      .dn_cx    (cord_cx[0]),
      .dn_cy    (cord_cy[0]),
      .dn_cz    (cord_cz[0])
   );

   for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cordic
      pra_cordic_stage #(
         .COORD_WIDTH (COORD_WIDTH),
         .STAGE_INDEX (g)
      ) u_stage (
         .clock    (clock),
         .reset    (reset),
         .load     (stage_ready[g+1]),
         .up_ctl   (cord_ctl[g]),
         .up_point (cord_point[g]),
         .up_cx    (cord_cx[g]),
         .up_cy    (cord_cy[g]),
         .up_cz    (cord_cz[g]),
         .dn_ctl   (cord_ctl[g+1]),
         .dn_point (cord_point[g+1]),
         .dn_cx    (cord_cx[g+1]),
         .dn_cy    (cord_cy[g+1]),
         .dn_cz    (cord_cz[g+1])
      );
   end

   for (genvar g = 0; g <= CORDIC_STAGES; g++) begin : g_cordic_valid
      assign vld[g] = cord_ctl[g].valid;
   end

   pra_rotate_mul #(
      .COORD_WIDTH (COORD_WIDTH)
   ) u_mul (
      .clock    (clock),
      .reset    (reset),
      .load     (stage_ready[MUL_IDX]),
      .up_ctl   (cord_ctl[CORDIC_STAGES]),
      .up_point (cord_point[CORDIC_STAGES]),
      .up_cx    (cord_cx[CORDIC_STAGES]),
      .up_cy    (cord_cy[CORDIC_STAGES]),
      .dn_ctl   (mul_ctl),
      .dn_point (mul_point),
      .dn_hi    (mul_hi),
      .dn_lo    (mul_lo)
   );

   pra_round_sat #(
      .COORD_WIDTH (COORD_WIDTH)
   ) u_round (
      .clock     (clock),
      .reset     (reset),
      .load_a    (stage_ready[JOIN_IDX]),
      .load_b    (stage_ready[OUT_IDX]),
      .up_ctl    (mul_ctl),
      .up_point  (mul_point),
      .up_hi     (mul_hi),
      .up_lo     (mul_lo),
      .mid_valid (join_valid),
      .dn_ctl    (out_ctl),
      .dn_x      (rsp_if.out_x),
      .dn_y      (rsp_if.out_y),
      .dn_z      (rsp_if.out_z)
   );

   assign vld[MUL_IDX]  = mul_ctl.valid;
   assign vld[JOIN_IDX] = join_valid;
   assign vld[OUT_IDX]  = out_ctl.valid;

   for (genvar g = 0; g < NUM_STAGES; g++) begin : g_ready
      assign stage_ready[g] = !vld[g] || stage_ready[g+1];
   end
   assign stage_ready[NUM_STAGES] = rsp_if.ready;

   assign req_if.ready = stage_ready[0];
   assign rsp_if.valid = out_ctl.valid;

   `PRA_ASSERT(a_accept_fills_prep, clock, reset, (req_if.valid && req_if.ready) |=> vld[0])
   `PRA_ASSERT_NOW(a_empty_pipe_ready, clock, reset, (vld != '0) || req_if.ready)
   `PRA_ASSERT(a_mul_holds_on_stall, clock, reset, !stage_ready[MUL_IDX] |=> vld[MUL_IDX])

endmodule

// ----- design/pra_angle_prep.sv -----
// Input stage: quadrant reduction of the angle and CORDIC start values.
module pra_angle_prep #(
   parameter int COORD_WIDTH = 32,
   parameter int ANGLE_WIDTH = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 load,
   input  pra_pkg::pipe_ctl_type                up_ctl,
   input  logic [ANGLE_WIDTH-1:0]               up_angle,
   input  logic [3*COORD_WIDTH-1:0]             up_point,
   output pra_pkg::pipe_ctl_type                dn_ctl,
   output logic [3*COORD_WIDTH-1:0]             dn_point,
   output logic signed [pra_pkg::TRIG_W-1:0]    dn_cx,
   output logic signed [pra_pkg::TRIG_W-1:0]    dn_cy,
   output logic signed [pra_pkg::Z_W-1:0]       dn_cz
);

   logic [31:0]                      turn;
   logic [31:0]                      rounded;
   logic [31:0]                      resid;
   pra_pkg::quad_type                quad_in;
   logic signed [pra_pkg::Z_W-1:0]   cz_in;

   logic                             valid_ff;
   pra_pkg::axis_type                axis_ff;
   pra_pkg::quad_type                quad_ff;
   logic [3*COORD_WIDTH-1:0]         point_ff;
   logic signed [pra_pkg::Z_W-1:0]   cz_ff;

   always_comb begin
      turn    = 32'(up_angle) << (32 - ANGLE_WIDTH);
      rounded = turn + 32'h2000_0000;
      quad_in = pra_pkg::quad_type'(rounded[31:30]);
      resid   = turn - {rounded[31:30], 30'd0};
      cz_in   = {{(pra_pkg::Z_W-32){resid[31]}}, resid};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= up_ctl.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         axis_ff  <= up_ctl.axis;
         quad_ff  <= quad_in;
         point_ff <= up_point;
         cz_ff    <= cz_in;
      end
   end

   assign dn_ctl   = '{valid: valid_ff, axis: axis_ff, quad: quad_ff};
   assign dn_point = point_ff;
   assign dn_cx    = pra_pkg::GAIN_Q30;
   assign dn_cy    = '0;
   assign dn_cz    = cz_ff;

endmodule

// ----- design/pra_cordic_stage.sv -----
// One registered rotation-mode CORDIC iteration with the point carried along.
module pra_cordic_stage #(
   parameter int COORD_WIDTH = 32,
   parameter int STAGE_INDEX = 0
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 load,
   input  pra_pkg::pipe_ctl_type                up_ctl,
   input  logic [3*COORD_WIDTH-1:0]             up_point,
   input  logic signed [pra_pkg::TRIG_W-1:0]    up_cx,
   input  logic signed [pra_pkg::TRIG_W-1:0]    up_cy,
   input  logic signed [pra_pkg::Z_W-1:0]       up_cz,
   output pra_pkg::pipe_ctl_type                dn_ctl,
   output logic [3*COORD_WIDTH-1:0]             dn_point,
   output logic signed [pra_pkg::TRIG_W-1:0]    dn_cx,
   output logic signed [pra_pkg::TRIG_W-1:0]    dn_cy,
   output logic signed [pra_pkg::Z_W-1:0]       dn_cz
);

   localparam logic signed [pra_pkg::Z_W-1:0] STEP =
      {{(pra_pkg::Z_W-32){1'b0}}, pra_pkg::ATAN_TURN[STAGE_INDEX]};

   logic signed [pra_pkg::TRIG_W-1:0] dx;
   logic signed [pra_pkg::TRIG_W-1:0] dy;
   logic signed [pra_pkg::TRIG_W-1:0] cx_in;
   logic signed [pra_pkg::TRIG_W-1:0] cy_in;
   logic signed [pra_pkg::Z_W-1:0]    cz_in;

   logic                              valid_ff;
   pra_pkg::axis_type                 axis_ff;
   pra_pkg::quad_type                 quad_ff;
   logic [3*COORD_WIDTH-1:0]          point_ff;
   logic signed [pra_pkg::TRIG_W-1:0] cx_ff;
   logic signed [pra_pkg::TRIG_W-1:0] cy_ff;
   logic signed [pra_pkg::Z_W-1:0]    cz_ff;

   always_comb begin
      dx = up_cy >>> STAGE_INDEX;
      dy = up_cx >>> STAGE_INDEX;
      if (!up_cz[pra_pkg::Z_W-1]) begin
         cx_in = up_cx - dx;
         cy_in = up_cy + dy;
         cz_in = up_cz - STEP;
      end else begin
         cx_in = up_cx + dx;
         cy_in = up_cy - dy;
         cz_in = up_cz + STEP;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= up_ctl.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         axis_ff  <= up_ctl.axis;
         quad_ff  <= up_ctl.quad;
         point_ff <= up_point;
         cx_ff    <= cx_in;
         cy_ff    <= cy_in;
         cz_ff    <= cz_in;
      end
   end

   assign dn_ctl   = '{valid: valid_ff, axis: axis_ff, quad: quad_ff};
   assign dn_point = point_ff;
   assign dn_cx    = cx_ff;
   assign dn_cy    = cy_ff;
   assign dn_cz    = cz_ff;

endmodule

// ----- design/pra_rotate_mul.sv -----
// Quadrant mapping of cosine and sine and the split coordinate products.
module pra_rotate_mul #(
   parameter int  COORD_WIDTH = 32,
   localparam int LO_W  = COORD_WIDTH / 2,
   localparam int HI_W  = COORD_WIDTH - LO_W,
   localparam int HPP_W = HI_W + pra_pkg::TRIG_W,
   localparam int LPP_W = LO_W + 1 + pra_pkg::TRIG_W
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 load,
   input  pra_pkg::pipe_ctl_type                up_ctl,
   input  logic [3*COORD_WIDTH-1:0]             up_point,
   input  logic signed [pra_pkg::TRIG_W-1:0]    up_cx,
   input  logic signed [pra_pkg::TRIG_W-1:0]    up_cy,
   output pra_pkg::pipe_ctl_type                dn_ctl,
   output logic [3*COORD_WIDTH-1:0]             dn_point,
   output logic signed [HPP_W-1:0]              dn_hi [4],
   output logic signed [LPP_W-1:0]              dn_lo [4]
);

   logic signed [pra_pkg::TRIG_W-1:0] cos_v;
   logic signed [pra_pkg::TRIG_W-1:0] sin_v;
   logic signed [pra_pkg::TRIG_W-1:0] nsin_v;
   logic [COORD_WIDTH-1:0]            px;
   logic [COORD_WIDTH-1:0]            py;
   logic [COORD_WIDTH-1:0]            pz;
   logic [COORD_WIDTH-1:0]            op_a;
   logic [COORD_WIDTH-1:0]            op_b;
   logic signed [HI_W-1:0]            a_hi;
   logic signed [HI_W-1:0]            b_hi;
   logic signed [LO_W:0]              a_lo;
   logic signed [LO_W:0]              b_lo;
   logic signed [HPP_W-1:0]           hi_in [4];
   logic signed [LPP_W-1:0]           lo_in [4];

   logic                              valid_ff;
   pra_pkg::axis_type                 axis_ff;
   pra_pkg::quad_type                 quad_ff;
   logic [3*COORD_WIDTH-1:0]          point_ff;
   logic signed [HPP_W-1:0]           hi_ff [4];
   logic signed [LPP_W-1:0]           lo_ff [4];

   always_comb begin
      case (up_ctl.quad)
         pra_pkg::QUAD_0: begin
            cos_v = up_cx;
            sin_v = up_cy;
         end
         pra_pkg::QUAD_1: begin
            cos_v = -up_cy;
            sin_v = up_cx;
         end
         pra_pkg::QUAD_2: begin
            cos_v = -up_cx;
            sin_v = -up_cy;
         end
         pra_pkg::QUAD_3: begin
            cos_v = up_cy;
            sin_v = -up_cx;
         end
      endcase
      nsin_v = -sin_v;

      px = up_point[COORD_WIDTH-1:0];
      py = up_point[2*COORD_WIDTH-1:COORD_WIDTH];
      pz = up_point[3*COORD_WIDTH-1:2*COORD_WIDTH];

      case (up_ctl.axis)
         pra_pkg::AXIS_X: begin
            op_a = py;
            op_b = pz;
         end
         pra_pkg::AXIS_Y: begin
            op_a = pz;
            op_b = px;
         end
         pra_pkg::AXIS_Z: begin
            op_a = py;
            op_b = px;
         end
         pra_pkg::AXIS_NONE: begin
            op_a = py;
            op_b = pz;
         end
      endcase

      a_hi = op_a[COORD_WIDTH-1:LO_W];
      b_hi = op_b[COORD_WIDTH-1:LO_W];
      a_lo = {1'b0, op_a[LO_W-1:0]};
      b_lo = {1'b0, op_b[LO_W-1:0]};

      hi_in[pra_pkg::PP_AC]  = a_hi * cos_v;
      lo_in[pra_pkg::PP_AC]  = a_lo * cos_v;
      hi_in[pra_pkg::PP_BNS] = b_hi * nsin_v;
      lo_in[pra_pkg::PP_BNS] = b_lo * nsin_v;
      hi_in[pra_pkg::PP_AS]  = a_hi * sin_v;
      lo_in[pra_pkg::PP_AS]  = a_lo * sin_v;
      hi_in[pra_pkg::PP_BC]  = b_hi * cos_v;
      lo_in[pra_pkg::PP_BC]  = b_lo * cos_v;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= up_ctl.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         axis_ff  <= up_ctl.axis;
         quad_ff  <= up_ctl.quad;
         point_ff <= up_point;
         hi_ff    <= hi_in;
         lo_ff    <= lo_in;
      end
   end

   assign dn_ctl   = '{valid: valid_ff, axis: axis_ff, quad: quad_ff};
   assign dn_point = point_ff;
   assign dn_hi    = hi_ff;
   assign dn_lo    = lo_ff;

endmodule

// ----- design/pra_round_sat.sv -----
// Product assembly, then rounding, saturation and placement of the results.
module pra_round_sat #(
   parameter int  COORD_WIDTH = 32,
   localparam int LO_W   = COORD_WIDTH / 2,
   localparam int HI_W   = COORD_WIDTH - LO_W,
   localparam int HPP_W  = HI_W + pra_pkg::TRIG_W,
   localparam int LPP_W  = LO_W + 1 + pra_pkg::TRIG_W,
   localparam int PROD_W = COORD_WIDTH + pra_pkg::TRIG_W,
   localparam int SUM_W  = PROD_W + 2
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 load_a,
   input  logic                                 load_b,
   input  pra_pkg::pipe_ctl_type                up_ctl,
   input  logic [3*COORD_WIDTH-1:0]             up_point,
   input  logic signed [HPP_W-1:0]              up_hi [4],
   input  logic signed [LPP_W-1:0]              up_lo [4],
   output logic                                 mid_valid,
   output pra_pkg::pipe_ctl_type                dn_ctl,
   output logic signed [COORD_WIDTH-1:0]        dn_x,
   output logic signed [COORD_WIDTH-1:0]        dn_y,
   output logic signed [COORD_WIDTH-1:0]        dn_z
);

   localparam int TOP_W = SUM_W - COORD_WIDTH - pra_pkg::TRIG_FRAC + 1;
   localparam logic [SUM_W-1:0] HALF =
      {{(SUM_W-pra_pkg::TRIG_FRAC){1'b0}}, 1'b1, {(pra_pkg::TRIG_FRAC-1){1'b0}}};

   function automatic logic [COORD_WIDTH-1:0] saturate(input logic [SUM_W-1:0] s);
      logic [TOP_W-1:0] top;
      top = s[SUM_W-1:COORD_WIDTH+pra_pkg::TRIG_FRAC-1];
      if (&top || !(|top)) begin
         return s[COORD_WIDTH+pra_pkg::TRIG_FRAC-1:pra_pkg::TRIG_FRAC];
      end else if (s[SUM_W-1]) begin
         return {1'b1, {(COORD_WIDTH-1){1'b0}}};
      end else begin
         return {1'b0, {(COORD_WIDTH-1){1'b1}}};
      end
   endfunction

   logic signed [PROD_W-1:0]     prod_in [4];
   logic [SUM_W-1:0]             sum_ra;
   logic [SUM_W-1:0]             sum_rb;
   logic [COORD_WIDTH-1:0]       res_a;
   logic [COORD_WIDTH-1:0]       res_b;
   logic [COORD_WIDTH-1:0]       px;
   logic [COORD_WIDTH-1:0]       py;
   logic [COORD_WIDTH-1:0]       pz;
   logic [COORD_WIDTH-1:0]       x_in;
   logic [COORD_WIDTH-1:0]       y_in;
   logic [COORD_WIDTH-1:0]       z_in;

   logic                         mid_valid_ff;
   pra_pkg::axis_type            mid_axis_ff;
   pra_pkg::quad_type            mid_quad_ff;
   logic [3*COORD_WIDTH-1:0]     mid_point_ff;
   logic signed [PROD_W-1:0]     prod_ff [4];

   logic                         valid_ff;
   pra_pkg::axis_type            axis_ff;
   pra_pkg::quad_type            quad_ff;
   logic [COORD_WIDTH-1:0]       x_ff;
   logic [COORD_WIDTH-1:0]       y_ff;
   logic [COORD_WIDTH-1:0]       z_ff;

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         prod_in[k] = (PROD_W'(up_hi[k]) <<< LO_W) + PROD_W'(up_lo[k]);
      end
   end

   always_comb begin
      sum_ra = SUM_W'(prod_ff[pra_pkg::PP_AC]) + SUM_W'(prod_ff[pra_pkg::PP_BNS]) + HALF;
      sum_rb = SUM_W'(prod_ff[pra_pkg::PP_AS]) + SUM_W'(prod_ff[pra_pkg::PP_BC]) + HALF;
      res_a  = saturate(sum_ra);
      res_b  = saturate(sum_rb);

      px = mid_point_ff[COORD_WIDTH-1:0];
      py = mid_point_ff[2*COORD_WIDTH-1:COORD_WIDTH];
      pz = mid_point_ff[3*COORD_WIDTH-1:2*COORD_WIDTH];

      case (mid_axis_ff)
         pra_pkg::AXIS_X: begin
            x_in = px;
            y_in = res_a;
            z_in = res_b;
         end
         pra_pkg::AXIS_Y: begin
            x_in = res_b;
            y_in = py;
            z_in = res_a;
         end
         pra_pkg::AXIS_Z: begin
            x_in = res_b;
            y_in = res_a;
            z_in = pz;
         end
         pra_pkg::AXIS_NONE: begin
            x_in = px;
            y_in = py;
            z_in = pz;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mid_valid_ff <= 1'b0;
         valid_ff     <= 1'b0;
      end else begin
         if (load_a) begin
            mid_valid_ff <= up_ctl.valid;
         end
         if (load_b) begin
            valid_ff <= mid_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load_a) begin
         mid_axis_ff  <= up_ctl.axis;
         mid_quad_ff  <= up_ctl.quad;
         mid_point_ff <= up_point;
         prod_ff      <= prod_in;
      end
      if (load_b) begin
         axis_ff <= mid_axis_ff;
         quad_ff <= mid_quad_ff;
         x_ff    <= x_in;
         y_ff    <= y_in;
         z_ff    <= z_in;
      end
   end

   assign mid_valid = mid_valid_ff;
   assign dn_ctl    = '{valid: valid_ff, axis: axis_ff, quad: quad_ff};
   assign dn_x      = x_ff;
   assign dn_y      = y_ff;
   assign dn_z      = z_ff;

endmodule

// ----- dv/rotation_monitor.sv -----
// Monitor that predicts each rotated point from accepted request words and checks responses.
`timescale 1ns / 100ps

module rotation_monitor #(
   parameter int CORDIC_STAGES = 16
) (
   input  logic clock,
   input  logic reset,
   pra_req_if   req_mon,
   pra_rsp_if   rsp_mon,
   output int   mismatches,
   output int   pending,
   output int   checked
);

   localparam longint CORDIC_GAIN = 64'sd652032874;
   localparam int     STAGE_COUNT = (CORDIC_STAGES < 32) ? CORDIC_STAGES : 32;

   localparam logic [31:0] ATAN_STEP [32] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
      32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
      32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
      32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
      32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
      32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
      32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
   };

   typedef struct packed {
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [31:0] z;
   } point_type;

   point_type rotated_points_due[$];
   int        fail_total  = 0;
   int        match_total = 0;
   int        due_total   = 0;

   assign mismatches = fail_total;
   assign checked    = match_total;
   assign pending    = due_total;

   function automatic void cordic_cos_sin(input logic [15:0] angle,
                                          output longint cos_v, output longint sin_v);
      logic [31:0]       turn;
      logic [32:0]       rounded;
      logic [31:0]       resid;
      pra_pkg::quad_type quad;
      longint            cx, cy, cz, dx, dy;
      turn    = {angle, 16'h0000};
      rounded = {1'b0, turn} + 33'h020000000;
      quad    = pra_pkg::quad_type'(rounded[31:30]);
      resid   = turn - {quad, 30'd0};
      cx      = CORDIC_GAIN;
      cy      = 0;
      cz      = longint'($signed(resid));
      for (int i = 0; i < STAGE_COUNT; i++) begin
         dx = cy >>> i;
         dy = cx >>> i;
         if (cz >= 0) begin
            cx = cx - dx;
            cy = cy + dy;
            cz = cz - longint'(ATAN_STEP[i]);
         end else begin
            cx = cx + dx;
            cy = cy - dy;
            cz = cz + longint'(ATAN_STEP[i]);
         end
      end
      case (quad)
         pra_pkg::QUAD_0: begin
            cos_v = cx;
            sin_v = cy;
         end
         pra_pkg::QUAD_1: begin
            cos_v = -cy;
            sin_v = cx;
         end
         pra_pkg::QUAD_2: begin
            cos_v = -cx;
            sin_v = -cy;
         end
         default: begin
            cos_v = cy;
            sin_v = -cx;
         end
      endcase
   endfunction

   // Both products are kept exact; the sum is rounded once, halves upward.
   function automatic logic signed [31:0] blend_round(input logic signed [31:0] a,
                                                      input longint ka,
                                                      input logic signed [31:0] b,
                                                      input longint kb);
      logic signed [127:0] acc;
      acc = a * ka + b * kb + (128'sd1 <<< 29);
      acc = acc >>> 30;
      if (acc > 128'sd2147483647) return 32'sh7FFFFFFF;
      if (acc < -128'sd2147483648) return 32'sh80000000;
      return acc[31:0];
   endfunction

   function automatic point_type rotate_point(input pra_pkg::axis_type axis,
                                              input logic [15:0] angle,
                                              input point_type p);
      point_type r;
      longint    c, s;
      cordic_cos_sin(angle, c, s);
      r = p;
      case (axis)
         pra_pkg::AXIS_X: begin
            r.y = blend_round(p.y, c, p.z, -s);
            r.z = blend_round(p.y, s, p.z, c);
         end
         pra_pkg::AXIS_Y: begin
            r.z = blend_round(p.z, c, p.x, -s);
            r.x = blend_round(p.z, s, p.x, c);
         end
         pra_pkg::AXIS_Z: begin
            r.y = blend_round(p.y, c, p.x, -s);
            r.x = blend_round(p.y, s, p.x, c);
         end
         default: r = p;
      endcase
      return r;
   endfunction

   task automatic check_coord(input string name, input logic signed [31:0] expected,
                              input logic signed [31:0] actual);
      if (actual !== expected) begin
         fail_total++;
         if (fail_total <= 10)
            $display("%0t: %s mismatch, expected %0d (%08h), actual %0d (%08h)",
                     $realtime, name, expected, expected, actual, actual);
      end
   endtask

   always @(posedge clock) begin
      point_type actual_pt, expected_pt, input_pt;
      if (!reset) begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            actual_pt = '{rsp_mon.out_x, rsp_mon.out_y, rsp_mon.out_z};
            if (rotated_points_due.size() == 0) begin
               fail_total++;
               if (fail_total <= 10)
                  $display("%0t: response word with no request outstanding: %0d %0d %0d",
                           $realtime, actual_pt.x, actual_pt.y, actual_pt.z);
            end else begin
               expected_pt = rotated_points_due.pop_front();
               check_coord("out_x", expected_pt.x, actual_pt.x);
               check_coord("out_y", expected_pt.y, actual_pt.y);
               check_coord("out_z", expected_pt.z, actual_pt.z);
               match_total++;
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            input_pt = '{req_mon.in_x, req_mon.in_y, req_mon.in_z};
            rotated_points_due.push_back(rotate_point(pra_pkg::axis_type'(req_mon.cmd),
                                                      req_mon.angle, input_pt));
         end
         due_total = rotated_points_due.size();
      end
   end

endmodule

// ----- dv/point_rotate_about_axis_tb.sv -----
// Testbench top that drives points into the rotation block and reports the verdict.
`timescale 1ns / 100ps

module point_rotate_about_axis_tb;

   localparam int LATENCY = 16 + 4;
   localparam logic signed [31:0] COORD_MAX = 32'sh7FFFFFFF;
   localparam logic signed [31:0] COORD_MIN = 32'sh80000000;

   logic clock = 1'b0;
   logic reset;
   int   mismatches, pending, checked;
   int   axis_count [4];
   bit   sender_eager = 1'b0;
   bit   sink_eager   = 1'b0;

   pra_req_if #(.COORD_WIDTH(32), .ANGLE_WIDTH(16)) req_if ();
   pra_rsp_if #(.COORD_WIDTH(32)) rsp_if ();

   point_rotate_about_axis #(
      .COORD_WIDTH(32),
      .ANGLE_WIDTH(16),
      .CORDIC_STAGES(16)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_if(req_if),
      .rsp_if(rsp_if)
   );

   rotation_monitor #(.CORDIC_STAGES(16)) rot_check (
      .clock(clock),
      .reset(reset),
      .req_mon(req_if),
      .rsp_mon(rsp_if),
      .mismatches(mismatches),
      .pending(pending),
      .checked(checked)
   );

   always #5 clock = ~clock;

   initial begin
      #2_000_000;
      $display("Verification failed");
      $finish;
   end

   // Before each word the receiver stalls for a random time, except in its eager spells.
   initial begin
      int stall;
      rsp_if.ready <= 1'b0;
      @(posedge clock);
      forever begin
         if ($urandom_range(0, 19) == 0) sink_eager = !sink_eager;
         stall = sink_eager ? 0 : $urandom_range(0, 15);
         if (stall > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         do @(posedge clock); while (!rsp_if.valid);
      end
   end

   task automatic send_point(input pra_pkg::axis_type axis, input logic [15:0] angle,
                             input logic signed [31:0] x, input logic signed [31:0] y,
                             input logic signed [31:0] z);
      int gap;
      if ($urandom_range(0, 19) == 0) sender_eager = !sender_eager;
      gap = sender_eager ? 0 : $urandom_range(0, 15);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.cmd   <= axis;
      req_if.angle <= angle;
      req_if.in_x  <= x;
      req_if.in_y  <= y;
      req_if.in_z  <= z;
      do @(posedge clock); while (!req_if.ready);
      axis_count[axis]++;
   endtask

   task automatic drain_results();
      req_if.valid <= 1'b0;
      @(posedge clock);
      wait (pending == 0);
      @(posedge clock);
   endtask

   function automatic logic signed [31:0] random_coord();
      logic signed [31:0] v;
      v = $urandom;
      case ($urandom_range(0, 5))
         0: begin
            case ($urandom_range(0, 4))
               0: v = COORD_MAX;
               1: v = COORD_MIN;
               2: v = 32'sd0;
               3: v = -32'sd1;
               default: v = 32'sd1;
            endcase
         end
         1, 2: v = $urandom;
         default: v = v >>> $urandom_range(1, 30);
      endcase
      return v;
   endfunction

   function automatic logic [15:0] random_angle();
      logic [15:0] a;
      if ($urandom_range(0, 3) == 0) begin
         a = 16'h2000 + 16'h4000 * 16'($urandom_range(0, 3));
         a = a + 16'($urandom_range(0, 8)) - 16'd4;
      end else begin
         a = 16'($urandom_range(0, 65535));
      end
      return a;
   endfunction

   initial begin
      reset        <= 1'b1;
      req_if.valid <= 1'b0;
      req_if.cmd   <= pra_pkg::AXIS_X;
      req_if.angle <= '0;
      req_if.in_x  <= '0;
      req_if.in_y  <= '0;
      req_if.in_z  <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Extremes of every field on each axis, including the pass-through selector.
      for (int a = 0; a < 4; a++) begin
         send_point(pra_pkg::axis_type'(a), 16'h0000, 32'sd1, -32'sd1, COORD_MAX);
         send_point(pra_pkg::axis_type'(a), 16'h4000, COORD_MAX, COORD_MIN, 32'sd0);
         send_point(pra_pkg::axis_type'(a), 16'h8000, COORD_MIN, COORD_MIN, COORD_MIN);
         send_point(pra_pkg::axis_type'(a), 16'h2000, COORD_MAX, COORD_MAX, COORD_MAX);
         send_point(pra_pkg::axis_type'(a), 16'hE000, COORD_MIN, COORD_MAX, COORD_MIN);
         send_point(pra_pkg::axis_type'(a), 16'hFFFF, COORD_MIN, COORD_MAX, -32'sd1);
      end
      drain_results();

      for (int n = 0; n < 400; n++) begin
         send_point(pra_pkg::axis_type'($urandom_range(0, 3)), random_angle(),
                    random_coord(), random_coord(), random_coord());
         if (n == 200) drain_results();
      end
      drain_results();
      repeat (2 * LATENCY) @(posedge clock);

      $display("Rotated %0d points: %0d about X, %0d about Y, %0d about Z, %0d passed through.",
               axis_count[0] + axis_count[1] + axis_count[2] + axis_count[3],
               axis_count[pra_pkg::AXIS_X], axis_count[pra_pkg::AXIS_Y],
               axis_count[pra_pkg::AXIS_Z], axis_count[pra_pkg::AXIS_NONE]);
      $display("Compared %0d response words, %0d mismatches, %0d still outstanding.",
               checked, mismatches, pending);
      if (mismatches == 0 && pending == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
